// File: src/mpkbf_pkg.sv
// ----------------------------------------------------------------------------
// mpkbf_pkg: shared types and constants of the prefix key filter
// Opcodes, status codes, alphabet decoding and sizing constants.
// ----------------------------------------------------------------------------
package mpkbf_pkg;

    localparam int unsigned MAX_FILTERS_DEF      = 4096;
    localparam int unsigned MAX_PREFIX_CHARS_DEF = 55;
    localparam int unsigned B32_FILTER_CHARS     = 51;
    localparam int unsigned B64_FILTER_CHARS     = 42;
    localparam int unsigned CHAR_CNT_MAX         = 63;
    localparam int unsigned KEY_BYTES            = 32;

    typedef enum logic [1:0] {
        OP_CHAR  = 2'd0,
        OP_KEY   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_CHAR = 3'd1,
        ST_BAD_LEN  = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_dec;

    function automatic t_dec decode_char(input logic kind, input logic [7:0] c);
        t_dec d;
        d.ok  = 1'b1;
        d.val = 6'd0;
        if (!kind) begin
            if (c >= 8'h61 && c <= 8'h7a) d.val = 6'(c - 8'h61);
            else if (c >= 8'h32 && c <= 8'h37) d.val = 6'(c - 8'h32 + 8'd26);
            else d.ok = 1'b0;
        end else begin
            if (c >= 8'h41 && c <= 8'h5a) d.val = 6'(c - 8'h41);
            else if (c >= 8'h61 && c <= 8'h7a) d.val = 6'(c - 8'h61 + 8'd26);
            else if (c >= 8'h30 && c <= 8'h39) d.val = 6'(c - 8'h30 + 8'd52);
            else if (c == 8'h2b) d.val = 6'd62;
            else if (c == 8'h2f) d.val = 6'd63;
            else d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

// File: src/mpkbf_mem.sv
// ----------------------------------------------------------------------------
// mpkbf_mem: filter table storage
// Single-port synchronous RAM, one 264-bit row per filter (bit count + words).
// ----------------------------------------------------------------------------
module mpkbf_mem #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12,
    parameter int unsigned DW    = 264
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: src/multi_prefix_key_bit_filter.sv
// ----------------------------------------------------------------------------
// multi_prefix_key_bit_filter: masked prefix match table over a 256-bit key
// Usage:
//   Input channel (i_valid/o_ready) carries op, value, last. Output channel
//   (o_valid/i_ready) carries status, hit, match_index, at most one per
//   input transaction. i_alphabet_we/i_alphabet_kind writes the alphabet.
//   Prefix characters are assembled in a 256-bit row register and written to
//   the filter RAM on a successful final character.
//   Non-final characters and key bytes leave the block ready for more input.
//   A final key byte walks a non-empty table: one RAM read per entry,
//   pipelined with the registered RAM output. The lowest matching entry is
//   the hit; a miss is reported once the last entry is checked.
//   A final prefix character sets the result register directly, without a walk.
//   The block takes a new transaction only once the receiver has taken the
//   pending result; a stalled receiver holds that register and the block waits.
//   Reset empties the table, clears key and prefix state and sets base32.
//   The RAM needs no clearing: only entries below the fill count are compared.
// ----------------------------------------------------------------------------
module multi_prefix_key_bit_filter
    import mpkbf_pkg::*;
#(
    parameter int unsigned MAX_FILTERS      = MAX_FILTERS_DEF,
    parameter int unsigned MAX_PREFIX_CHARS = MAX_PREFIX_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_value,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic        o_hit,
    output logic [11:0] o_match_index,
    input  logic        i_alphabet_we,
    input  logic        i_alphabet_kind
);
    localparam int unsigned AW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int unsigned CW = $clog2(MAX_FILTERS + 1);
    localparam int unsigned DW = 264;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state         r_state;
    logic           r_kind;
    logic [CW-1:0]  r_count;
    logic [255:0]   r_key;
    logic [4:0]     r_kpos;
    logic [5:0]     r_ccnt;
    logic           r_bad;
    logic [255:0]   r_row;
    logic [AW-1:0]  r_addr;
    logic [CW-1:0]  r_rd_idx;
    logic           r_rd_vld;
    logic [CW-1:0]  r_issue;
    logic [2:0]     r_st;
    logic           r_hit;
    logic [11:0]    r_idx;
    logic           r_ovld;

    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [DW-1:0]  mem_wdata;
    logic [DW-1:0]  mem_rdata;

    mpkbf_mem #(.DEPTH(MAX_FILTERS), .AW(AW), .DW(DW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    logic         accept;
    logic         room;
    t_dec         dec;
    logic [2:0]   nbits;
    logic [5:0]   fchars;
    logic [5:0]   maxlen;
    logic [5:0]   n_ccnt;
    logic [7:0]   pos;
    logic [255:0] row_base;
    logic [255:0] row_new;
    logic [5:0]   nchars;
    logic [7:0]   bitcnt;
    logic [255:0] key_base;
    logic [255:0] key_new;
    logic         key_end;
    logic [255:0] lmask;
    logic         row_match;

    assign o_ready = (r_state == S_IDLE) && !r_ovld;
    assign accept  = i_valid && o_ready;
    assign room    = r_count < CW'(MAX_FILTERS);
    assign dec     = decode_char(r_kind, i_value);
    assign nbits   = r_kind ? 3'd6 : 3'd5;
    assign fchars  = r_kind ? 6'(B64_FILTER_CHARS) : 6'(B32_FILTER_CHARS);
    assign maxlen  = r_kind ? 6'(B64_FILTER_CHARS) : 6'(MAX_PREFIX_CHARS);
    assign n_ccnt  = (r_ccnt < 6'(CHAR_CNT_MAX)) ? r_ccnt + 6'd1 : r_ccnt;
    assign pos     = 8'(r_ccnt) * 8'(nbits);
    assign nchars  = (n_ccnt < fchars) ? n_ccnt : fchars;
    assign bitcnt  = 8'(nchars) * 8'(nbits);
    assign key_end = i_last || (r_kpos == 5'd31);

    always_comb begin
        row_base = (r_ccnt == 6'd0) ? '0 : r_row;
        row_new  = row_base;
        if (dec.ok && r_ccnt < fchars) begin
            if (r_kind) begin
                row_new = row_base | ({250'd0, dec.val} << (8'd250 - pos));
            end else begin
                row_new = row_base | ({251'd0, dec.val[4:0]} << (8'd251 - pos));
            end
        end
        key_base = (r_kpos == 5'd0) ? '0 : r_key;
        key_new  = key_base | ({248'd0, i_value} << (8'd248 - {r_kpos, 3'd0}));
    end

    always_comb begin
        lmask = '1;
        if (mem_rdata[263:256] == 8'd0) lmask = '0;
        else lmask = ~('1 >> mem_rdata[263:256]);
        row_match = ((r_key ^ mem_rdata[255:0]) & lmask) == '0;
    end

    always_comb begin
        mem_we    = accept && i_op == OP_CHAR && i_last && room &&
                    !(n_ccnt > maxlen) && !(r_bad || !dec.ok);
        mem_wdata = {bitcnt, row_new};
        mem_addr  = (r_state == S_WALK) ? r_addr : AW'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= 1'b0;
            r_count  <= '0;
            r_key    <= '0;
            r_kpos   <= '0;
            r_ccnt   <= '0;
            r_bad    <= 1'b0;
            r_ovld   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
            r_issue  <= '0;
            r_rd_idx <= '0;
        end else begin
            if (i_alphabet_we) r_kind <= i_alphabet_kind;
            if (r_ovld && i_ready) r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_op)
                            OP_CHAR: begin
                                if (room) r_row <= row_new;
                                if (i_last) begin
                                    r_ccnt <= '0;
                                    r_bad  <= 1'b0;
                                    r_ovld <= 1'b1;
                                    r_hit  <= 1'b0;
                                    r_idx  <= '0;
                                    if (!room) r_st <= ST_FULL;
                                    else if (n_ccnt > maxlen) r_st <= ST_BAD_LEN;
                                    else if (r_bad || !dec.ok) r_st <= ST_BAD_CHAR;
                                    else begin
                                        r_st    <= ST_OK;
                                        r_idx   <= 12'(r_count);
                                        r_count <= r_count + CW'(1);
                                    end
                                end else begin
                                    r_ccnt <= n_ccnt;
                                    if (!dec.ok) r_bad <= 1'b1;
                                end
                            end
                            OP_KEY: begin
                                r_key <= key_new;
                                if (key_end) begin
                                    r_kpos <= '0;
                                    if (r_count == '0) begin
                                        r_st   <= ST_EMPTY;
                                        r_hit  <= 1'b0;
                                        r_idx  <= '0;
                                        r_ovld <= 1'b1;
                                    end else begin
                                        r_state  <= S_WALK;
                                        r_addr   <= '0;
                                        r_issue  <= CW'(1);
                                        r_rd_vld <= 1'b1;
                                        r_rd_idx <= '0;
                                    end
                                end else begin
                                    r_kpos <= r_kpos + 5'd1;
                                end
                            end
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_ccnt  <= '0;
                                r_bad   <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK: begin
                    // read for r_addr issues this cycle; data checked next cycle
                    r_rd_vld <= r_issue <= r_count;
                    r_rd_idx <= r_issue - CW'(1);
                    r_addr   <= AW'(r_issue);
                    r_issue  <= r_issue + CW'(1);
                    if (r_rd_vld && (r_state == S_WALK) && r_issue > CW'(1)) begin
                        if (row_match) begin
                            r_st    <= ST_OK;
                            r_hit   <= 1'b1;
                            r_idx   <= 12'(r_rd_idx);
                            r_state <= S_OUT;
                        end else if (r_rd_idx == r_count - CW'(1)) begin
                            r_st    <= ST_OK;
                            r_hit   <= 1'b0;
                            r_idx   <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovld) begin
                        r_ovld  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ovld;
    assign o_status      = r_st;
    assign o_hit         = r_hit;
    assign o_match_index = r_idx;
endmodule

// File: src/mpkbf_checker.sv
// ----------------------------------------------------------------------------
// mpkbf_checker: port-level checks of the prefix key filter
// Handshake and result consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
module mpkbf_checker
    import mpkbf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic        o_hit,
    input logic [11:0] o_match_index
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_match_index))
        else $error("result dropped under stall");

    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_status == ST_OK)
        else $error("hit with error status");

    a_err_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_match_index == 12'd0 && !o_hit)
        else $error("error result carries index");

    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while result stalled");
endmodule

bind multi_prefix_key_bit_filter mpkbf_checker u_mpkbf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_hit        (o_hit),
    .o_match_index(o_match_index)
);

// File: test/multi_prefix_key_bit_filter_test.sv
// ----------------------------------------------------------------------------
// multi_prefix_key_bit_filter_test: self-checking bench for the prefix filter
// Drives prefix characters, key bytes, clears and ignored ops through the
// valid/ready input channel. Every result is compared with an in-bench model
// of the filter table or a typed value. Stimulus: a directed table, random
// well-formed prefix/key runs with noise, then a larger table fill and walk.
// ----------------------------------------------------------------------------
module multi_prefix_key_bit_filter_test
    import mpkbf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NFILT     = 4096;
    localparam int unsigned NFILL     = 192;
    localparam int unsigned CYC_LIMIT = 3000000;

    typedef struct {
        t_status    st;
        logic       hit;
        logic [11:0] idx;
    } t_match_res;

    typedef struct {
        int         cfg;
        t_op        op;
        logic [7:0] value;
        logic       last;
        bit         typed;
        t_status    st;
        logic       hit;
        logic [11:0] idx;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op = OP_NONE;
    logic [7:0]  i_value = '0;
    logic        i_last = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic        o_hit;
    logic [11:0] o_match_index;
    logic        i_alphabet_we = 1'b0;
    logic        i_alphabet_kind = 1'b0;

    multi_prefix_key_bit_filter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_hit          (o_hit),
        .o_match_index  (o_match_index),
        .i_alphabet_we  (i_alphabet_we),
        .i_alphabet_kind(i_alphabet_kind)
    );

    always #2 i_clk = ~i_clk;

    // filter table model
    logic [255:0] flt_row [NFILT];
    logic [7:0]   flt_bits [NFILT];
    int unsigned  flt_count = 0;
    logic [255:0] asm_row = '0;
    logic [255:0] key_acc = '0;
    int unsigned  key_pos = 0;
    int unsigned  pfx_chars = 0;
    bit           pfx_bad = 0;
    bit           alpha = 0;

    t_match_res   pending_q[$];
    int unsigned  errors = 0;
    int unsigned  n_items = 0;
    int unsigned  n_checked = 0;
    int unsigned  n_hits = 0;
    int unsigned  cyc = 0;
    int unsigned  burst_left = 0;

    function automatic int char_code(bit k, logic [7:0] c);
        if (!k) begin
            if (c inside {["a":"z"]}) return int'(c) - "a";
            if (c inside {["2":"7"]}) return int'(c) - "2" + 26;
            return -1;
        end
        if (c inside {["A":"Z"]}) return int'(c) - "A";
        if (c inside {["a":"z"]}) return int'(c) - "a" + 26;
        if (c inside {["0":"9"]}) return int'(c) - "0" + 52;
        if (c == "+") return 62;
        if (c == "/") return 63;
        return -1;
    endfunction

    function automatic logic [7:0] code_char(bit k, int v);
        if (!k) return (v < 26) ? 8'("a" + v) : 8'("2" + v - 26);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? 8'("+") : 8'("/");
    endfunction

    function automatic logic [255:0] lead_mask(int unsigned nb);
        if (nb == 0) return '0;
        return ~256'(0) << (256 - nb);
    endfunction

    function automatic bit filter_step(t_op op, logic [7:0] v, logic last,
                                       output t_match_res r);
        int          d;
        bit          room;
        int unsigned c, nb, fch, maxl, n;
        logic [255:0] m;
        r = '{ST_OK, 1'b0, 12'd0};
        case (op)
            OP_CHAR: begin
                d    = char_code(alpha, v);
                room = flt_count < NFILT;
                c    = pfx_chars;
                nb   = alpha ? 6 : 5;
                fch  = alpha ? B64_FILTER_CHARS : B32_FILTER_CHARS;
                maxl = alpha ? B64_FILTER_CHARS : MAX_PREFIX_CHARS_DEF;
                if (d < 0) pfx_bad = 1;
                if (room) begin
                    if (c == 0) asm_row = '0;
                    if (d >= 0 && c < fch)
                        for (int k = 0; k < nb; k++)
                            if ((d >> (nb - 1 - k)) & 1)
                                asm_row[255 - ((nb * c + k) & 255)] = 1'b1;
                end
                if (pfx_chars < CHAR_CNT_MAX) pfx_chars++;
                if (!last) return 0;
                if (!room) r.st = ST_FULL;
                else if (pfx_chars > maxl) r.st = ST_BAD_LEN;
                else if (pfx_bad) r.st = ST_BAD_CHAR;
                else begin
                    n = (pfx_chars < fch) ? pfx_chars : fch;
                    flt_row[flt_count]  = asm_row;
                    flt_bits[flt_count] = 8'(n * nb);
                    r.idx = 12'(flt_count);
                    flt_count++;
                end
                pfx_chars = 0;
                pfx_bad   = 0;
                return 1;
            end
            OP_KEY: begin
                if (key_pos == 0) key_acc = '0;
                key_acc[255 - 8 * key_pos -: 8] = v;
                if (!last && key_pos != KEY_BYTES - 1) begin
                    key_pos++;
                    return 0;
                end
                key_pos = 0;
                if (flt_count == 0) begin
                    r.st = ST_EMPTY;
                    return 1;
                end
                for (int unsigned i = 0; i < flt_count; i++) begin
                    m = lead_mask(flt_bits[i]);
                    if (((key_acc ^ flt_row[i]) & m) == '0) begin
                        r.hit = 1'b1;
                        r.idx = 12'(i);
                        return 1;
                    end
                end
                return 1;
            end
            OP_CLEAR: begin
                flt_count = 0;
                pfx_chars = 0;
                pfx_bad   = 0;
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    // send one transaction; typed expectation overrides the model's result
    task automatic send_txn(t_op op, logic [7:0] v, logic last,
                            bit typed = 0, t_match_res tr = '{ST_OK, 1'b0, 12'd0});
        int unsigned gap;
        t_match_res  r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_value <= v;
        i_last  <= last;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
        n_items++;
        if (filter_step(op, v, last, r)) pending_q.push_back(typed ? tr : r);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_alphabet(bit k);
        drain();
        i_alphabet_we   <= 1'b1;
        i_alphabet_kind <= k;
        @(posedge i_clk);
        i_alphabet_we   <= 1'b0;
        alpha = k;
    endtask

    task automatic send_prefix(int unsigned len, int unsigned bad_pct);
        logic [7:0] c;
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < bad_pct) c = 8'($urandom_range(0, 255));
            else c = code_char(alpha, $urandom_range(0, alpha ? 63 : 31));
            send_txn(OP_CHAR, c, i == len - 1);
        end
    endtask

    task automatic send_key(logic [255:0] key, int unsigned len, bit mark_end);
        for (int unsigned p = 0; p < len; p++)
            send_txn(OP_KEY, key[255 - 8 * p -: 8], (p == len - 1) && mark_end);
    endtask

    function automatic logic [255:0] rand_256();
        logic [255:0] x;
        for (int i = 0; i < 8; i++) x[32 * i +: 32] = $urandom;
        return x;
    endfunction

    // receiver: stall pattern rotates through four modes picked by cyc[8:7]
    always @(posedge i_clk) begin
        t_match_res e;
        cyc <= cyc + 1;
        case (cyc[8:7])
            2'd0: i_ready <= 1'b1;
            2'd1: i_ready <= $urandom_range(0, 1);
            2'd2: i_ready <= (cyc[1:0] == 2'd0);
            default: i_ready <= ($urandom_range(0, 7) != 0);
        endcase
        if (i_rst_n && o_valid && i_ready) begin
            n_checked++;
            if (pending_q.size() == 0) begin
                $error("unexpected result status=%0d hit=%0d index=%0d",
                       o_status, o_hit, o_match_index);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_hit) n_hits++;
                if (o_status !== e.st) begin
                    $error("status: expected %0d, got %0d", e.st, o_status);
                    errors++;
                end
                if (o_hit !== e.hit) begin
                    $error("hit: expected %0d, got %0d", e.hit, o_hit);
                    errors++;
                end
                if (o_match_index !== e.idx) begin
                    $error("match_index: expected %0d, got %0d", e.idx, o_match_index);
                    errors++;
                end
            end
        end
        if (cyc == CYC_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cyc, pending_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    localparam int NROWS = 24;
    t_stim_row dir_rows [NROWS] = '{
        '{-1, OP_KEY,   8'hFF, 1'b1, 1, ST_EMPTY,    1'b0, 12'd0},
        '{-1, OP_CHAR,  "a",   1'b0, 0, ST_OK,       1'b0, 12'd0},
        '{-1, OP_CHAR,  "7",   1'b1, 1, ST_OK,       1'b0, 12'd0},
        '{-1, OP_CHAR,  "z",   1'b1, 1, ST_OK,       1'b0, 12'd1},
        '{-1, OP_CHAR,  "!",   1'b1, 1, ST_BAD_CHAR, 1'b0, 12'd0},
        '{-1, OP_CHAR,  "A",   1'b0, 0, ST_OK,       1'b0, 12'd0},
        '{-1, OP_CHAR,  "b",   1'b1, 1, ST_BAD_CHAR, 1'b0, 12'd0},
        '{-1, OP_KEY,   8'h00, 1'b0, 0, ST_OK,       1'b0, 12'd0},
        '{-1, OP_KEY,   8'hFF, 1'b1, 0, ST_OK,       1'b0, 12'd0},
        '{-1, OP_KEY,   8'h07, 1'b0, 0, ST_OK,       1'b0, 12'd0},
        '{-1, OP_KEY,   8'hC0, 1'b1, 0, ST_OK,       1'b0, 12'd0},
        '{-1, OP_NONE,  8'hFF, 1'b1, 0, ST_OK,       1'b0, 12'd0},
        '{ 1, OP_CHAR,  "A",   1'b0, 0, ST_OK,       1'b0, 12'd0},
        '{-1, OP_CHAR,  "+",   1'b0, 0, ST_OK,       1'b0, 12'd0},
        '{-1, OP_CHAR,  "/",   1'b0, 0, ST_OK,       1'b0, 12'd0},
        '{-1, OP_CHAR,  "9",   1'b1, 1, ST_OK,       1'b0, 12'd2},
        '{-1, OP_CHAR,  "z",   1'b0, 0, ST_OK,       1'b0, 12'd0},
        '{ 0, OP_CHAR,  "b",   1'b1, 0, ST_OK,       1'b0, 12'd0},
        '{-1, OP_CHAR,  8'h00, 1'b1, 1, ST_BAD_CHAR, 1'b0, 12'd0},
        '{-1, OP_KEY,   8'hFC, 1'b0, 0, ST_OK,       1'b0, 12'd0},
        '{-1, OP_KEY,   8'h3F, 1'b1, 0, ST_OK,       1'b0, 12'd0},
        '{-1, OP_CLEAR, 8'h00, 1'b0, 0, ST_OK,       1'b0, 12'd0},
        '{-1, OP_KEY,   8'h5A, 1'b1, 1, ST_EMPTY,    1'b0, 12'd0},
        '{-1, OP_CLEAR, 8'hFF, 1'b1, 0, ST_OK,       1'b0, 12'd0}
    };

    initial begin
        logic [255:0] key;
        logic [255:0] m;
        int unsigned  j, sel, len;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg >= 0) set_alphabet(dir_rows[i].cfg[0]);
            send_txn(dir_rows[i].op, dir_rows[i].value, dir_rows[i].last,
                     dir_rows[i].typed, '{dir_rows[i].st, dir_rows[i].hit, dir_rows[i].idx});
        end
        // length limits under both alphabets, count saturation under base32
        send_prefix(55, 0);
        send_prefix(56, 0);
        send_prefix(70, 0);
        set_alphabet(1);
        send_prefix(42, 0);
        send_prefix(43, 0);
        send_key('1, 32, 0);
        send_key('0, 32, 1);

        while (n_items < 1050) begin
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                set_alphabet($urandom_range(0, 1));
            end else if (sel < 7 || flt_count > 48) begin
                send_txn(OP_CLEAR, 8'($urandom), 1'($urandom));
            end else if (sel < 10) begin
                send_txn(OP_NONE, 8'($urandom), 1'($urandom));
            end else if (sel < 50) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70)
                                                   : $urandom_range(1, 8);
                send_prefix(len, ($urandom_range(0, 9) == 0) ? 30 : 0);
            end else begin
                key = rand_256();
                if (flt_count > 0 && $urandom_range(0, 9) < 7) begin
                    j = $urandom_range(0, flt_count - 1);
                    m = lead_mask(flt_bits[j]);
                    key = (flt_row[j] & m) | (key & ~m);
                end
                if ($urandom_range(0, 9) < 6) send_key(key, 32, $urandom_range(0, 1));
                else send_key(key, $urandom_range(1, 32), 1);
            end
        end

        // fill a larger table with distinct 3-character prefixes
        set_alphabet(0);
        send_txn(OP_CLEAR, 8'h00, 1'b0);
        for (int unsigned i = 0; i < NFILL; i++) begin
            send_txn(OP_CHAR, code_char(0, (i >> 10) & 31), 1'b0);
            send_txn(OP_CHAR, code_char(0, (i >> 5) & 31), 1'b0);
            send_txn(OP_CHAR, code_char(0, i & 31), 1'b1);
        end
        for (int i = 0; i < 4; i++) begin
            j = (i == 0) ? NFILL - 1 : $urandom_range(0, NFILL - 1);
            key = rand_256();
            key[255 -: 15] = 15'(j);
            send_key(key, 32, 1);
        end
        send_txn(OP_CLEAR, 8'h00, 1'b0);
        send_prefix(3, 0);
        send_key(rand_256(), 32, 0);

        drain();
        repeat (NFILL + 50) @(posedge i_clk);
        $display("%0d transactions sent, %0d results checked, %0d key hits;",
                 n_items, n_checked, n_hits);
        $display("both alphabets, short/long prefixes and a walk over %0d entries",
                 NFILL);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
src/mpkbf_pkg.sv
src/mpkbf_mem.sv
src/multi_prefix_key_bit_filter.sv
src/mpkbf_checker.sv
test/multi_prefix_key_bit_filter_test.sv
